[design/tolerant_vertex_weld_defines.svh]
// ----------------------------------------------------------------------------
// tolerant_vertex_weld_defines
// Assertion macros used by the vertex weld checker.
// ----------------------------------------------------------------------------
`ifndef TOLERANT_VERTEX_WELD_DEFINES_SVH
`define TOLERANT_VERTEX_WELD_DEFINES_SVH

// checked only out of reset
`define TVW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tvw assertion failed");

// checked during reset too
`define TVW_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tvw reset assertion failed");

`endif

[design/tvw_pkg.sv]
// ----------------------------------------------------------------------------
// tvw_pkg
// Types, widths and the per-axis tolerance compare for the vertex weld.
// ----------------------------------------------------------------------------
package tvw_pkg;

  localparam int COORD_W          = 16;
  localparam int TOL_W            = 16;
  localparam int POS_W            = 10;
  localparam int APB_DW           = 32;
  localparam int APB_AW           = 2;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int REG_TOLERANCE    = 0;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctl_t;

  function automatic logic axis_close(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        mag;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag  = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
    return mag <= {1'b0, tol};
  endfunction

endpackage

[design/tvw_cell.sv]
// ----------------------------------------------------------------------------
// tvw_cell
// One table entry. Compares the passing request with its stored vertex and
// hands the request on to the next cell through its output registers.
// ----------------------------------------------------------------------------
module tvw_cell #(
  parameter int MAX_VERTICES = tvw_pkg::MAX_VERTICES_DEF,
  parameter int IDX          = 0,
  localparam int IW          = $clog2(MAX_VERTICES),
  localparam int CW          = $clog2(MAX_VERTICES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [tvw_pkg::TOL_W-1:0] tol_i,
  input  logic [CW-1:0]            cnt_i,
  input  logic                     wr_en_i,
  input  logic [IW-1:0]            wr_addr_i,
  input  tvw_pkg::vec_t            wr_pos_i,
  input  logic [IW-1:0]            wr_idx_i,
  input  tvw_pkg::tok_ctl_t        ctl_i,
  input  tvw_pkg::vec_t            pos_i,
  input  logic [IW-1:0]            where_i,
  input  logic [IW-1:0]            idx_i,
  output tvw_pkg::tok_ctl_t        ctl_o,
  output tvw_pkg::vec_t            pos_o,
  output logic [IW-1:0]            where_o,
  output logic [IW-1:0]            idx_o
);
  import tvw_pkg::*;

  logic [IW-1:0] my_idx;
  vec_t          ent_pos_r;
  logic [IW-1:0] ent_idx_r;
  logic          live;

  tok_ctl_t      ctl_r,   ctl_nxt;
  vec_t          pos_r,   pos_nxt;
  logic [IW-1:0] where_r, where_nxt;
  logic [IW-1:0] idx_r,   idx_nxt;

  assign my_idx = IW'(IDX);

  assign live = ctl_i.valid && !ctl_i.hit && (cnt_i > CW'(IDX)) &&
                axis_close(pos_i.x, ent_pos_r.x, tol_i) &&
                axis_close(pos_i.y, ent_pos_r.y, tol_i) &&
                axis_close(pos_i.z, ent_pos_r.z, tol_i);

  always_comb begin
    ctl_nxt.valid = ctl_i.valid;
    ctl_nxt.hit   = ctl_i.hit | live;
    pos_nxt       = pos_i;
    where_nxt     = live ? my_idx : where_i;
    idx_nxt       = live ? ent_idx_r : idx_i;
  end

  always_ff @(posedge clk) begin
    if (wr_en_i && (wr_addr_i == my_idx)) begin
      ent_pos_r <= wr_pos_i;
      ent_idx_r <= wr_idx_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    where_r <= where_nxt;
    idx_r   <= idx_nxt;
  end

  assign ctl_o   = ctl_r;
  assign pos_o   = pos_r;
  assign where_o = where_r;
  assign idx_o   = idx_r;

endmodule

[design/tolerant_vertex_weld.sv]
// ----------------------------------------------------------------------------
// tolerant_vertex_weld
// Streaming vertex welder: each request walks a row of table cells, merges
// into the first stored vertex within tolerance, or is kept with a new index.
//
//   channel   ports                      direction  flow
//   in        in_valid / in_stall        in         restart + x/y/z
//   out       out_valid / out_stall      out        merged, positions, full
//   cfg       psel/penable/pwrite/...    in         tolerance register
//
// A request passes a load stage, then one cell a cycle, then end and output
// stages; the next request is accepted only after its result has moved into
// the output register.
// Full table: no walk; the result goes straight to the end register and then
// to the output register, and the next request is taken after that.
// Reset clears counters, control and tolerance only; restart clears table counts.
// A result waits in the output register under out_stall; the next request is
// taken meanwhile and parks its result until the register frees.
// ----------------------------------------------------------------------------
module tolerant_vertex_weld #(
  parameter int MAX_VERTICES = tvw_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  input  logic signed [tvw_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [tvw_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [tvw_pkg::COORD_W-1:0] in_pos_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_merged,
  output logic [tvw_pkg::POS_W-1:0]         out_match_position,
  output logic [tvw_pkg::POS_W-1:0]         out_written_index,
  output logic                              out_table_full,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tvw_pkg::APB_AW-1:0]        paddr,
  input  logic [tvw_pkg::APB_DW-1:0]        pwdata,
  output logic [tvw_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import tvw_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t            st_r, st_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic [TOL_W-1:0]  tol_r;

  tok_ctl_t          tok_ctl_r, tok_ctl_nxt;
  vec_t              tok_pos_r, tok_pos_nxt;

  logic              res_merged_r, res_merged_nxt;
  logic [POS_W-1:0]  res_where_r, res_where_nxt;
  logic [POS_W-1:0]  res_widx_r, res_widx_nxt;
  logic              res_full_r, res_full_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_merged_r, out_merged_nxt;
  logic [POS_W-1:0]  out_where_r, out_where_nxt;
  logic [POS_W-1:0]  out_widx_r, out_widx_nxt;
  logic              out_full_r, out_full_nxt;

  tok_ctl_t          chain_ctl   [0:MAX_VERTICES];
  vec_t              chain_pos   [0:MAX_VERTICES];
  logic [IW-1:0]     chain_where [0:MAX_VERTICES];
  logic [IW-1:0]     chain_idx   [0:MAX_VERTICES];

  tok_ctl_t          end_ctl;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     wr_idx;
  logic [IW-1:0]     fin_where;
  logic              cfg_wr;

  assign chain_ctl[0]   = tok_ctl_r;
  assign chain_pos[0]   = tok_pos_r;
  assign chain_where[0] = '0;
  assign chain_idx[0]   = '0;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    tvw_cell #(
      .MAX_VERTICES (MAX_VERTICES),
      .IDX          (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tol_i     (tol_r),
      .cnt_i     (cnt_r),
      .wr_en_i   (wr_en),
      .wr_addr_i (wr_addr),
      .wr_pos_i  (chain_pos[MAX_VERTICES]),
      .wr_idx_i  (wr_idx),
      .ctl_i     (chain_ctl[k]),
      .pos_i     (chain_pos[k]),
      .where_i   (chain_where[k]),
      .idx_i     (chain_idx[k]),
      .ctl_o     (chain_ctl[k+1]),
      .pos_o     (chain_pos[k+1]),
      .where_o   (chain_where[k+1]),
      .idx_o     (chain_idx[k+1])
    );
  end

  assign end_ctl   = chain_ctl[MAX_VERTICES];
  assign wr_en     = (st_r == ST_RUN) && end_ctl.valid;
  assign wr_addr   = cnt_r[IW-1:0];
  assign wr_idx    = end_ctl.hit ? chain_idx[MAX_VERTICES] : kept_r[IW-1:0];
  assign fin_where = end_ctl.hit ? chain_where[MAX_VERTICES] : cnt_r[IW-1:0];

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    kept_nxt       = kept_r;
    tok_ctl_nxt    = '0;
    tok_pos_nxt    = tok_pos_r;
    res_merged_nxt = res_merged_r;
    res_where_nxt  = res_where_r;
    res_widx_nxt   = res_widx_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r;
    out_merged_nxt = out_merged_r;
    out_where_nxt  = out_where_r;
    out_widx_nxt   = out_widx_r;
    out_full_nxt   = out_full_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt       = in_restart ? '0 : cnt_r;
          kept_nxt      = in_restart ? '0 : kept_r;
          tok_pos_nxt.x = in_pos_x;
          tok_pos_nxt.y = in_pos_y;
          tok_pos_nxt.z = in_pos_z;
          if (cnt_nxt == CW'(MAX_VERTICES)) begin
            res_merged_nxt = 1'b0;
            res_where_nxt  = '0;
            res_widx_nxt   = '0;
            res_full_nxt   = 1'b1;
            st_nxt         = ST_PUSH;
          end else begin
            tok_ctl_nxt.valid = 1'b1;
            st_nxt            = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (end_ctl.valid) begin
          cnt_nxt = cnt_r + CW'(1);
          if (!end_ctl.hit) begin
            kept_nxt = kept_r + CW'(1);
          end
          res_merged_nxt = end_ctl.hit;
          res_where_nxt  = POS_W'(fin_where);
          res_widx_nxt   = POS_W'(wr_idx);
          res_full_nxt   = 1'b0;
          st_nxt         = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_merged_nxt = res_merged_r;
          out_where_nxt  = res_where_r;
          out_widx_nxt   = res_widx_r;
          out_full_nxt   = res_full_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == APB_AW'(4 * REG_TOLERANCE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      kept_r      <= '0;
      tok_ctl_r   <= '0;
      out_valid_r <= 1'b0;
      tol_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      kept_r      <= kept_nxt;
      tok_ctl_r   <= tok_ctl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        tol_r <= pwdata[TOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_pos_r    <= tok_pos_nxt;
    res_merged_r <= res_merged_nxt;
    res_where_r  <= res_where_nxt;
    res_widx_r   <= res_widx_nxt;
    res_full_r   <= res_full_nxt;
    out_merged_r <= out_merged_nxt;
    out_where_r  <= out_where_nxt;
    out_widx_r   <= out_widx_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign in_stall           = (st_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_merged         = out_merged_r;
  assign out_match_position = out_where_r;
  assign out_written_index  = out_widx_r;
  assign out_table_full     = out_full_r;
  assign prdata             = APB_DW'(tol_r);
  assign pready             = 1'b1;

endmodule

[design/tvw_checker.sv]
// ----------------------------------------------------------------------------
// tvw_checker
// Port-level checks on the vertex weld, bound to the top level.
// ----------------------------------------------------------------------------
`include "tolerant_vertex_weld_defines.svh"

module tvw_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_merged,
  input logic [tvw_pkg::POS_W-1:0] out_match_position,
  input logic [tvw_pkg::POS_W-1:0] out_written_index,
  input logic                      out_table_full
);

  // one request in the cell row at a time
  `TVW_ASSERT(a_busy_after_req, in_valid && !in_stall |=> in_stall)

  `TVW_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_merged) && $stable(out_match_position) && $stable(out_written_index) && $stable(out_table_full))

  // full table answers with zero fields
  `TVW_ASSERT(a_full_zero, out_valid && out_table_full |-> !out_merged && out_match_position == '0 && out_written_index == '0)

  `TVW_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !in_stall)

endmodule

bind tolerant_vertex_weld tvw_checker u_tvw_checker (.*);
